// ===== rtl/cdd_pkg.sv =====
// Shared types, constants and calendar helper functions for the date
// decrement block. No dependencies.
package cdd_pkg;

  localparam int CMD_W    = 3;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 16;
  localparam int AMOUNT_W = 16;

  // Wide working year: covers the start year less ten times the largest amount.
  localparam int WYEAR_W  = 21;
  // Remainder register for the year modulo 400.
  localparam int REM_W    = 20;
  localparam int RES_W    = 9;
  // Step counter: holds seven times the largest amount.
  localparam int CNT_W    = AMOUNT_W + 3;
  // Restoring reduction modulo 400, one shifted modulus per cycle.
  localparam int MOD_STEPS = 12;
  localparam int MIDX_W    = 4;

  localparam logic [CMD_W-1:0] CMD_DAYS         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WEEKS        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MONTHS       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_YEARS_STEP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_YEARS_DIRECT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEC_STEP     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DEC_DIRECT   = 3'd6;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0] DAY_FEB   = 5'd28;
  localparam logic [DAY_W-1:0] DAY_LONG  = 5'd31;

  localparam logic [REM_W-1:0]  MOD_BASE    = 20'd400;
  localparam logic [WYEAR_W-1:0] YEAR_OFFSET = 21'd688400;
  localparam logic signed [WYEAR_W-1:0] YEAR_MIN = -21'sd32768;
  localparam logic [YEAR_W-1:0] YEAR_SAT = 16'h8000;

  typedef struct packed {
    logic                load;
    logic                mod_step;
    logic [MIDX_W-1:0]   mod_idx;
    logic                run_step;
    logic                out_load;
  } cdd_ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_free;
  } cdd_stat_t;

  function automatic logic is_leap(input logic [RES_W-1:0] r);
    return (r == 9'd0) ||
           ((r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MONTH_FEB:                   len = leap ? DAY_LEAP : DAY_FEB;
      4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
      default:                     len = DAY_LONG;
    endcase
    return len;
  endfunction

  function automatic logic [RES_W-1:0] res_dec1(input logic [RES_W-1:0] r);
    return (r == 9'd0) ? 9'd399 : r - 9'd1;
  endfunction

  function automatic logic [RES_W-1:0] res_dec10(input logic [RES_W-1:0] r);
    return (r < 9'd10) ? r + 9'd390 : r - 9'd10;
  endfunction

endpackage

// ===== rtl/cdd_in_if.sv =====
// Request channel carrying a start date, an amount and a command.
// Depends on cdd_pkg for field widths.
interface cdd_in_if;
  logic                              valid;
  logic                              ready;
  logic [cdd_pkg::CMD_W-1:0]         cmd;
  logic [cdd_pkg::DAY_W-1:0]         start_day;
  logic [cdd_pkg::MONTH_W-1:0]       start_month;
  logic signed [cdd_pkg::YEAR_W-1:0] start_year;
  logic [cdd_pkg::AMOUNT_W-1:0]      amount;

  modport source (output valid, cmd, start_day, start_month, start_year, amount,
                  input ready);
  modport sink   (input valid, cmd, start_day, start_month, start_year, amount,
                  output ready);
endinterface

// ===== rtl/cdd_out_if.sv =====
// Result channel carrying the earlier date and the year saturation flag.
// Depends on cdd_pkg for field widths.
interface cdd_out_if;
  logic                              valid;
  logic                              ready;
  logic [cdd_pkg::DAY_W-1:0]         result_day;
  logic [cdd_pkg::MONTH_W-1:0]       result_month;
  logic signed [cdd_pkg::YEAR_W-1:0] result_year;
  logic                              year_underflow;

  modport source (output valid, result_day, result_month, result_year, year_underflow,
                  input ready);
  modport sink   (input valid, result_day, result_month, result_year, year_underflow,
                  output ready);
endinterface

// ===== rtl/cdd_ctrl.sv =====
// Controller for the date decrement block: sequences load, modulo-400
// reduction, stepping and result hand-off. Depends on cdd_pkg.
module cdd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdd_pkg::cdd_stat_t stat,
  output cdd_pkg::cdd_ctrl_t ctrl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [cdd_pkg::MIDX_W-1:0]   idx_r, idx_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ctrl          = '0;
    ctrl.mod_idx  = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          idx_nxt   = cdd_pkg::MIDX_W'(cdd_pkg::MOD_STEPS - 1);
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        ctrl.mod_step = 1'b1;
        idx_nxt       = idx_r - 1'b1;
        if (idx_r == '0) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.cnt_zero) begin
          state_nxt = ST_DONE;
        end else begin
          ctrl.run_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== rtl/cdd_dp.sv =====
// Datapath for the date decrement block: date registers, wide year, year
// residue modulo 400, step counter and output register. Depends on cdd_pkg.
module cdd_dp (
  input  logic               clk,
  input  logic               rst_n,
  cdd_in_if.sink             in_ch,
  cdd_out_if.source          out_ch,
  input  cdd_pkg::cdd_ctrl_t ctrl,
  output cdd_pkg::cdd_stat_t stat
);

  logic [cdd_pkg::CMD_W-1:0]           cmd_r;
  logic [cdd_pkg::DAY_W-1:0]           d_r, d_nxt;
  logic [cdd_pkg::MONTH_W-1:0]         m_r, m_nxt;
  logic signed [cdd_pkg::WYEAR_W-1:0]  y_r, y_nxt;
  logic [cdd_pkg::REM_W-1:0]           rem_r, rem_nxt;
  logic [cdd_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;

  logic [cdd_pkg::DAY_W-1:0]           d_load;
  logic [cdd_pkg::MONTH_W-1:0]         m_load;
  logic signed [cdd_pkg::WYEAR_W-1:0]  y_load;
  logic [cdd_pkg::WYEAR_W-1:0]         y_biased;
  logic [cdd_pkg::CNT_W-1:0]           cnt_load;
  logic [cdd_pkg::REM_W-1:0]           mod_sub;

  logic [cdd_pkg::RES_W-1:0]           res, res_m1, res_m10;
  logic [cdd_pkg::MONTH_W-1:0]         m_prev;
  logic [cdd_pkg::DAY_W-1:0]           len_prev, d_fixed;
  logic                                direct, under;

  logic                                out_valid_r;
  logic [cdd_pkg::DAY_W-1:0]           out_day_r;
  logic [cdd_pkg::MONTH_W-1:0]         out_month_r;
  logic [cdd_pkg::YEAR_W-1:0]          out_year_r;
  logic                                out_under_r;

  // Loading: clamp month and day, form the wide year and the step count.
  always_comb begin
    d_load = (in_ch.start_day == '0) ? cdd_pkg::DAY_FIRST : in_ch.start_day;
    if (in_ch.start_month == '0) begin
      m_load = cdd_pkg::MONTH_JAN;
    end else if (in_ch.start_month > cdd_pkg::MONTH_DEC) begin
      m_load = cdd_pkg::MONTH_DEC;
    end else begin
      m_load = in_ch.start_month;
    end
    y_load   = cdd_pkg::WYEAR_W'(in_ch.start_year);
    cnt_load = '0;
    case (in_ch.cmd)
      cdd_pkg::CMD_YEARS_DIRECT:
        y_load = y_load - $signed({5'd0, in_ch.amount});
      cdd_pkg::CMD_DEC_DIRECT:
        y_load = y_load - $signed({2'd0, in_ch.amount, 3'd0})
                        - $signed({4'd0, in_ch.amount, 1'b0});
      cdd_pkg::CMD_WEEKS:
        cnt_load = {in_ch.amount, 3'd0} - {3'd0, in_ch.amount};
      cdd_pkg::CMD_DAYS, cdd_pkg::CMD_MONTHS, cdd_pkg::CMD_YEARS_STEP,
      cdd_pkg::CMD_DEC_STEP:
        cnt_load = {3'd0, in_ch.amount};
      default: cnt_load = '0;
    endcase
    y_biased = y_load + cdd_pkg::YEAR_OFFSET;
  end

  assign mod_sub  = cdd_pkg::MOD_BASE << ctrl.mod_idx;
  assign res      = rem_r[cdd_pkg::RES_W-1:0];
  assign res_m1   = cdd_pkg::res_dec1(res);
  assign res_m10  = cdd_pkg::res_dec10(res);
  assign m_prev   = m_r - 1'b1;
  assign len_prev = cdd_pkg::days_in(m_prev, cdd_pkg::is_leap(res));
  assign direct   = (cmd_r == cdd_pkg::CMD_YEARS_DIRECT) ||
                    (cmd_r == cdd_pkg::CMD_DEC_DIRECT);
  assign d_fixed  = (direct && m_r == cdd_pkg::MONTH_FEB && d_r == cdd_pkg::DAY_LEAP &&
                     !cdd_pkg::is_leap(res)) ? cdd_pkg::DAY_FEB : d_r;
  assign under    = (y_r < cdd_pkg::YEAR_MIN);

  always_comb begin
    d_nxt   = d_r;
    m_nxt   = m_r;
    y_nxt   = y_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      d_nxt   = d_load;
      m_nxt   = m_load;
      y_nxt   = y_load;
      rem_nxt = y_biased[cdd_pkg::REM_W-1:0];
      cnt_nxt = cnt_load;
    end else if (ctrl.mod_step) begin
      if (rem_r >= mod_sub) begin
        rem_nxt = rem_r - mod_sub;
      end
    end else if (ctrl.run_step) begin
      cnt_nxt = cnt_r - 1'b1;
      case (cmd_r)
        cdd_pkg::CMD_DAYS, cdd_pkg::CMD_WEEKS: begin
          if (d_r > cdd_pkg::DAY_FIRST) begin
            d_nxt = d_r - 1'b1;
          end else if (m_r == cdd_pkg::MONTH_JAN) begin
            y_nxt   = y_r - 21'sd1;
            rem_nxt = {11'd0, res_m1};
            m_nxt   = cdd_pkg::MONTH_DEC;
            d_nxt   = cdd_pkg::DAY_LONG;
          end else begin
            m_nxt = m_prev;
            d_nxt = len_prev;
          end
        end
        cdd_pkg::CMD_MONTHS: begin
          if (m_r == cdd_pkg::MONTH_JAN) begin
            y_nxt   = y_r - 21'sd1;
            rem_nxt = {11'd0, res_m1};
            m_nxt   = cdd_pkg::MONTH_DEC;
          end else begin
            m_nxt = m_prev;
            if (d_r > len_prev) begin
              d_nxt = len_prev;
            end
          end
        end
        cdd_pkg::CMD_YEARS_STEP: begin
          y_nxt   = y_r - 21'sd1;
          rem_nxt = {11'd0, res_m1};
          if (m_r == cdd_pkg::MONTH_FEB && d_r == cdd_pkg::DAY_LEAP &&
              !cdd_pkg::is_leap(res_m1)) begin
            d_nxt = cdd_pkg::DAY_FEB;
          end
        end
        cdd_pkg::CMD_DEC_STEP: begin
          y_nxt   = y_r - 21'sd10;
          rem_nxt = {11'd0, res_m10};
          if (m_r == cdd_pkg::MONTH_FEB && d_r == cdd_pkg::DAY_LEAP &&
              !cdd_pkg::is_leap(res_m10)) begin
            d_nxt = cdd_pkg::DAY_FEB;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_ch.cmd;
    end
    d_r   <= d_nxt;
    m_r   <= m_nxt;
    y_r   <= y_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_day_r   <= d_fixed;
      out_month_r <= m_r;
      out_year_r  <= under ? cdd_pkg::YEAR_SAT : y_r[cdd_pkg::YEAR_W-1:0];
      out_under_r <= under;
    end
  end

  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_day     = out_day_r;
  assign out_ch.result_month   = out_month_r;
  assign out_ch.result_year    = out_year_r;
  assign out_ch.year_underflow = out_under_r;

endmodule

// ===== rtl/calendar_date_decrement.sv =====
// Top level of the Gregorian date decrement block: joins controller and
// datapath. Depends on cdd_pkg, cdd_in_if, cdd_out_if, cdd_ctrl and cdd_dp.
//
// Usage: a request on in_ch carries a start date, an amount and a command
// (days, weeks, months, stepwise or direct years, stepwise or direct decades).
// The block returns one earlier date on out_ch for each request, with the
// year saturated at -32768 and year_underflow raised when it would go lower.
// Only one request is in work at a time; in_ch.ready is high while the block
// is free. A request is loaded, its year is reduced modulo 400, one step is
// taken per cycle, a check finds no steps left and the result is handed off.
// The next request is taken only after that hand-off. The number of steps is 0
// for direct modes and the amount (seven times it for weeks) for stepwise modes.
// The result sits in an output register, so the next request is taken while
// it waits; if the receiver still stalls when the next result is ready, that
// result waits in the datapath until the register frees. Synchronous
// active-low reset empties the output register and returns the controller to
// idle.
module calendar_date_decrement (
  input  logic      clk,
  input  logic      rst_n,
  cdd_in_if.sink    in_ch,
  cdd_out_if.source out_ch
);

  cdd_pkg::cdd_ctrl_t ctrl;
  cdd_pkg::cdd_stat_t stat;

  cdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  cdd_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .ctrl   (ctrl),
    .stat   (stat)
  );

  // A saturated year must read as the lower limit.
  a_under_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.year_underflow |-> out_ch.result_year == $signed(cdd_pkg::YEAR_SAT))
    else $error("underflow flagged without a saturated year");

  // Every result month lies in the calendar.
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.result_month >= 4'd1) && (out_ch.result_month <= 4'd12))
    else $error("result month out of range");

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while a previous one is in work");

  // A result is handed to the output register only while it is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> stat.out_free)
    else $error("result loaded over one not yet taken");

endmodule
